/* src/pvd_pkg.sv */
// Shared types and constants for the PES video depacketizer.
// Used by pes_video_depacketizer and its port checker; no dependencies.
package pvd_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 2097152;
  localparam int unsigned FCNT_W          = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned OUT_CNT_W       = 22;
  localparam int unsigned LOOK_DEPTH      = 5;
  localparam int unsigned RUN_W           = $clog2(LOOK_DEPTH + 2);

  localparam logic [7:0] VIDEO_ID_RESET = 8'hE0;
  localparam logic [7:0] SC_ZERO        = 8'h00;
  localparam logic [7:0] SC_ONE         = 8'h01;
  localparam logic [7:0] NAL_SPS        = 8'h67;
  localparam logic [7:0] NAL_IDR_SLICE  = 8'h65;
  localparam logic [7:0] NAL_P_SLICE    = 8'h61;
  localparam logic [7:0] NAL_SEI        = 8'h06;
  localparam logic [7:0] NAL_AUD        = 8'h09;

  localparam logic [8:0] HDR_SC0     = 9'd0;
  localparam logic [8:0] HDR_SC1     = 9'd1;
  localparam logic [8:0] HDR_SC2     = 9'd2;
  localparam logic [8:0] HDR_ID      = 9'd3;
  localparam logic [8:0] HDR_LEN_HI  = 9'd4;
  localparam logic [8:0] HDR_LEN_LO  = 9'd5;
  localparam logic [8:0] HDR_HDL     = 9'd8;
  localparam logic [16:0] PES_FIXED  = 17'd3;

  localparam logic KIND_BYTE      = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [4:0] {
    PH_WAIT   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_SKIP   = 5'b00100,
    PH_LOOK   = 5'b01000,
    PH_STREAM = 5'b10000
  } phase_t;

endpackage

/* src/pes_video_depacketizer.sv */
// Top level of the PES video depacketizer: parser, lookahead and result serializer.
// Depends on pvd_pkg.
//
// Takes one program-stream byte per cycle while in_tready is high and parses
// video PES packets in a single registered pass: each accepted word updates
// the parser and loads a result run of zero to six words (an optional
// frame-end record, then up to five payload bytes) into the output register.
// Streamed payload gives at most one result per byte, so a byte is taken
// every cycle while the sink is ready. When the lookahead of up to five bytes
// is released, the run drains one word per cycle while the sink is ready and
// the input stalls until the last word of the run is taken. in_tready is high
// when the output register is empty or its last word leaves in the same cycle.
module pes_video_depacketizer
  import pvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  logic        in_tuser,   // [0] packet_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] payload_byte, [29:8] frame_byte_count,
                                  // [30] frame_is_key, [31] zero
  output logic        out_tuser,  // [0] record_kind
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [7:0]        vsid_r;
  phase_t            phase_r, phase_nxt;
  logic [8:0]        idx_r, idx_nxt;
  logic [15:0]       pes_r, pes_nxt;
  logic [7:0]        hdl_r, hdl_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [7:0]        la_r [LOOK_DEPTH];
  logic [7:0]        la_nxt [LOOK_DEPTH];
  logic [2:0]        lacnt_r, lacnt_nxt;
  logic              fwd_r, fwd_nxt;
  logic              slice_r, slice_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic              pend_r, pend_nxt;
  logic              key_r, key_nxt;

  logic [RUN_W-1:0]  left_r, left_nxt;
  logic [RUN_W-1:0]  pos_r;
  logic              end_r, end_nxt;
  logic [FCNT_W-1:0] ecnt_r, ecnt_nxt;
  logic              ekey_r, ekey_nxt;
  logic [7:0]        rb_r [LOOK_DEPTH];
  logic [7:0]        rb_nxt [LOOK_DEPTH];

  logic        in_acc, out_acc;
  logic [7:0]  b;
  phase_t      ph;
  logic [8:0]  ix;
  logic [2:0]  n;
  logic [15:0] rem_dec;
  logic [16:0] need;
  logic        sc, nal_sps, nal_slice, nal_drop, hdr_bad;
  logic [FCNT_W:0] fsum;
  logic [RUN_W-1:0] bidx;
  logic [7:0]  sel_byte;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (left_r == '0) || ((left_r == RUN_W'(1)) && out_tready);

  assign b  = in_tdata;
  assign ph = in_tuser ? PH_HEADER : phase_r;
  assign ix = in_tuser ? '0 : idx_r;
  assign n  = lacnt_r + 3'd1;
  assign rem_dec = rem_r - 16'd1;
  assign need = {9'b0, b} + PES_FIXED;

  always_comb begin
    for (int i = 0; i < LOOK_DEPTH; i++) begin
      la_nxt[i] = (lacnt_r == 3'(i)) ? b : la_r[i];
    end
  end

  assign sc = (n >= 3'd4) && (la_nxt[0] == SC_ZERO) && (la_nxt[1] == SC_ZERO) &&
              (la_nxt[2] == SC_ZERO) && (la_nxt[3] == SC_ONE);
  assign nal_sps   = (n >= 3'd5) && sc && (la_nxt[4] == NAL_SPS);
  assign nal_slice = (n >= 3'd5) && sc &&
                     ((la_nxt[4] == NAL_IDR_SLICE) || (la_nxt[4] == NAL_P_SLICE));
  assign nal_drop  = (n >= 3'd5) && sc &&
                     ((la_nxt[4] == NAL_SEI) || (la_nxt[4] == NAL_AUD));
  assign hdr_bad = ((ix == HDR_SC0) && (b != SC_ZERO)) ||
                   ((ix == HDR_SC1) && (b != SC_ZERO)) ||
                   ((ix == HDR_SC2) && (b != SC_ONE)) ||
                   ((ix == HDR_ID) && (b != vsid_r));

  always_comb begin
    phase_nxt = ph;
    idx_nxt   = ix;
    pes_nxt   = pes_r;
    hdl_nxt   = hdl_r;
    rem_nxt   = rem_r;
    lacnt_nxt = in_tuser ? 3'd0 : lacnt_r;
    fwd_nxt   = in_tuser ? 1'b0 : fwd_r;
    slice_nxt = slice_r;
    fcnt_nxt  = fcnt_r;
    pend_nxt  = pend_r;
    key_nxt   = key_r;
    left_nxt  = '0;
    end_nxt   = 1'b0;
    ecnt_nxt  = fcnt_r;
    ekey_nxt  = key_r;
    fsum      = '0;
    for (int i = 0; i < LOOK_DEPTH; i++) begin
      rb_nxt[i] = la_nxt[i];
    end
    unique case (ph)
      PH_HEADER: begin
        if (hdr_bad) begin
          phase_nxt = PH_WAIT;
        end else begin
          if (ix == HDR_LEN_HI) begin
            pes_nxt = {b, 8'h00};
          end else if (ix == HDR_LEN_LO) begin
            pes_nxt = {pes_r[15:8], b};
          end
          if (ix == HDR_HDL) begin
            hdl_nxt = b;
            rem_nxt = ({1'b0, pes_r} >= need) ? 16'(pes_r - 16'(need)) : 16'd0;
            idx_nxt = '0;
            if (b != 8'd0) begin
              phase_nxt = PH_SKIP;
            end else begin
              lacnt_nxt = 3'd0;
              fwd_nxt   = 1'b0;
              phase_nxt = (rem_nxt == 16'd0) ? PH_WAIT : PH_LOOK;
            end
          end else begin
            idx_nxt = ix + 9'd1;
          end
        end
      end
      PH_SKIP: begin
        idx_nxt = idx_r + 9'd1;
        if (idx_nxt >= {1'b0, hdl_r}) begin
          lacnt_nxt = 3'd0;
          fwd_nxt   = 1'b0;
          phase_nxt = (rem_r == 16'd0) ? PH_WAIT : PH_LOOK;
        end
      end
      PH_LOOK: begin
        lacnt_nxt = n;
        rem_nxt   = rem_dec;
        if ((n >= 3'd5) || (rem_dec == 16'd0)) begin
          phase_nxt = (rem_dec == 16'd0) ? PH_WAIT : PH_STREAM;
          if (slice_r && sc) begin
            end_nxt   = 1'b1;
            fcnt_nxt  = '0;
            slice_nxt = 1'b0;
            pend_nxt  = 1'b1;
          end
          if (nal_slice) begin
            slice_nxt = 1'b1;
          end
          fwd_nxt = !nal_drop;
          if (!nal_drop) begin
            if (pend_nxt) begin
              key_nxt  = nal_sps;
              pend_nxt = 1'b0;
            end
            fsum = {1'b0, fcnt_nxt} + (FCNT_W + 1)'(n);
            fcnt_nxt = (fsum > (FCNT_W + 1)'(MAX_FRAME_BYTES)) ?
                       FCNT_W'(MAX_FRAME_BYTES) : fsum[FCNT_W-1:0];
            left_nxt = RUN_W'(n) + RUN_W'(end_nxt);
          end else begin
            left_nxt = RUN_W'(end_nxt);
          end
        end
      end
      PH_STREAM: begin
        rb_nxt[0] = b;
        if (fwd_r) begin
          fsum = {1'b0, fcnt_r} + (FCNT_W + 1)'(1);
          fcnt_nxt = (fsum > (FCNT_W + 1)'(MAX_FRAME_BYTES)) ?
                     FCNT_W'(MAX_FRAME_BYTES) : fsum[FCNT_W-1:0];
          left_nxt = RUN_W'(1);
        end
        rem_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_nxt = PH_WAIT;
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsid_r  <= VIDEO_ID_RESET;
      phase_r <= PH_WAIT;
      idx_r   <= '0;
      pes_r   <= '0;
      hdl_r   <= '0;
      rem_r   <= '0;
      lacnt_r <= '0;
      fwd_r   <= 1'b0;
      slice_r <= 1'b0;
      fcnt_r  <= '0;
      pend_r  <= 1'b1;
      key_r   <= 1'b0;
      left_r  <= '0;
      pos_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        vsid_r <= cfg_wr_data;
      end
      if (in_acc) begin
        phase_r  <= phase_nxt;
        idx_r    <= idx_nxt;
        pes_r    <= pes_nxt;
        hdl_r    <= hdl_nxt;
        rem_r    <= rem_nxt;
        lacnt_r  <= lacnt_nxt;
        fwd_r    <= fwd_nxt;
        slice_r  <= slice_nxt;
        fcnt_r   <= fcnt_nxt;
        pend_r   <= pend_nxt;
        key_r    <= key_nxt;
        left_r   <= left_nxt;
        pos_r    <= '0;
      end else if (out_acc) begin
        left_r <= left_r - RUN_W'(1);
        pos_r  <= pos_r + RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (ph == PH_LOOK) begin
        for (int i = 0; i < LOOK_DEPTH; i++) begin
          la_r[i] <= la_nxt[i];
        end
      end
      end_r  <= end_nxt;
      ecnt_r <= ecnt_nxt;
      ekey_r <= ekey_nxt;
      for (int i = 0; i < LOOK_DEPTH; i++) begin
        rb_r[i] <= rb_nxt[i];
      end
    end
  end

  assign bidx = pos_r - RUN_W'(end_r);

  always_comb begin
    case (bidx)
      RUN_W'(0): sel_byte = rb_r[0];
      RUN_W'(1): sel_byte = rb_r[1];
      RUN_W'(2): sel_byte = rb_r[2];
      RUN_W'(3): sel_byte = rb_r[3];
      RUN_W'(4): sel_byte = rb_r[4];
      default:   sel_byte = 8'h00;
    endcase
  end

  logic is_end;
  assign is_end = end_r && (pos_r == '0);

  assign out_tvalid = (left_r != '0);
  assign out_tlast  = (left_r == RUN_W'(1));
  assign out_tuser  = is_end ? KIND_FRAME_END : KIND_BYTE;
  assign out_tdata  = is_end ? {1'b0, ekey_r, OUT_CNT_W'(ecnt_r), 8'h00}
                             : {1'b0, 1'b0, OUT_CNT_W'(0), sel_byte};

endmodule

/* src/pvd_checker.sv */
// Port-level checker for pes_video_depacketizer, bound to the top level.
// Depends on pvd_pkg for the record kind codes.
module pvd_checker
  import pvd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || (out_tlast && out_tready))
    else $error("input taken while a run is still pending");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_FRAME_END) |-> out_tdata[7:0] == 8'h00)
    else $error("frame-end record carries a payload byte");

  a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_BYTE) |-> out_tdata[31:8] == 24'h0)
    else $error("payload word carries frame fields");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind pes_video_depacketizer pvd_checker u_pvd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
